[sv/bmm_pkg.sv]
// Shared types, codes and constants of the batched matrix multiply block.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package bmm_pkg;

	localparam int OPCODE_W   = 2;
	localparam int SLICE_W    = 2;
	localparam int ROW_W      = 3;
	localparam int COL_W      = 3;
	localparam int VALUE_W    = 32;
	localparam int PROD_W     = 2 * VALUE_W;
	localparam int TAG_W      = 3;
	localparam int DIM_CFG_W  = 4;
	localparam int BAT_CFG_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	localparam int MAX_DIM_DEF   = 8;
	localparam int MAX_BATCH_DEF = 4;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [DIM_CFG_W-1:0] ROWS_RST   = 4'd8;
	localparam logic [DIM_CFG_W-1:0] INNER_RST  = 4'd8;
	localparam logic [DIM_CFG_W-1:0] COLS_RST   = 4'd8;
	localparam logic [BAT_CFG_W-1:0] BATCH_RST  = 3'd1;
	localparam logic                 SHARED_RST = 1'b1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD_LEFT  = 2'd0,
		OP_LOAD_RIGHT = 2'd1,
		OP_COMPUTE    = 2'd2,
		OP_NOP        = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS   = 3'd0,
		CFG_INNER  = 3'd1,
		CFG_COLS   = 3'd2,
		CFG_BATCH  = 3'd3,
		CFG_SHARED = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic             valid;
		logic             first;
		logic [TAG_W-1:0] tag;
	} meta_t;

	typedef struct packed {
		meta_t                     meta;
		logic signed [PROD_W-1:0]  prod;
	} pass_t;

endpackage

[sv/bmm_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on bmm_pkg for field widths.
interface bmm_in_if;
	logic                            valid;
	logic                            ready;
	logic [bmm_pkg::OPCODE_W-1:0]    opcode;
	logic [bmm_pkg::SLICE_W-1:0]     slice;
	logic [bmm_pkg::ROW_W-1:0]       row;
	logic [bmm_pkg::COL_W-1:0]       col;
	logic signed [bmm_pkg::VALUE_W-1:0] value;

	modport source (output valid, opcode, slice, row, col, value, input ready);
	modport sink (input valid, opcode, slice, row, col, value, output ready);
endinterface

interface bmm_out_if;
	logic                            valid;
	logic                            ready;
	logic [bmm_pkg::SLICE_W-1:0]     out_slice;
	logic [bmm_pkg::ROW_W-1:0]       out_row;
	logic [bmm_pkg::COL_W-1:0]       out_col;
	logic signed [bmm_pkg::VALUE_W-1:0] product;
	logic                            last;

	modport source (output valid, out_slice, out_row, out_col, product, last, input ready);
	modport sink (input valid, out_slice, out_row, out_col, product, last, output ready);
endinterface

[sv/batched_matrix_multiply_top.sv]
// Batched matrix multiply: left and right stores, sequencer, shared
// multiplier and the accumulator cell chain. Depends on bmm_pkg, bmm_if,
// bmm_ram and bmm_cell.
//
// Load items (left or right element) and no-ops are taken in the idle
// state, so loads stream at one transfer per cycle between computes. A
// compute item works row by row: for each result row the sequencer reads
// one left and one right element per cycle, one shared 32x32 multiplier
// feeds the products into a chain of MAX_DIM cells, and each cell
// accumulates the exact sum of its column. After the chain is flushed in
// the wait state, the row sums shift out of the chain head through floor
// scaling and saturation, one result per cycle while the output does not
// stall. The single multiplier does one MAC per cycle. New items are taken
// only between computes; the result register holds a finished result while
// the next item is taken.
module batched_matrix_multiply_top #(
	parameter int MAX_DIM   = bmm_pkg::MAX_DIM_DEF,
	parameter int MAX_BATCH = bmm_pkg::MAX_BATCH_DEF,
	parameter int FRAC_BITS = bmm_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bmm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmm_pkg::CFG_DATA_W-1:0] cfg_data,
	bmm_in_if.sink                        items,
	bmm_out_if.source                     results
);
	localparam int DEPTH    = MAX_BATCH * MAX_DIM * MAX_DIM;
	localparam int AW       = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int IW       = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
	localparam int CW       = $clog2(MAX_DIM + 1);
	localparam int BW       = $clog2(MAX_BATCH + 1);
	localparam int ACC_W    = bmm_pkg::PROD_W + $clog2(MAX_DIM) + 1;
	localparam int WAIT_LEN = MAX_DIM + 2;
	localparam int WW       = $clog2(WAIT_LEN + 1);
	localparam int VW       = bmm_pkg::VALUE_W;

	// Configuration registers
	logic [bmm_pkg::DIM_CFG_W-1:0] rows_cfg_q, inner_cfg_q, cols_cfg_q;
	logic [bmm_pkg::BAT_CFG_W-1:0] batch_cfg_q;
	logic                          shared_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q   <= bmm_pkg::ROWS_RST;
			inner_cfg_q  <= bmm_pkg::INNER_RST;
			cols_cfg_q   <= bmm_pkg::COLS_RST;
			batch_cfg_q  <= bmm_pkg::BATCH_RST;
			shared_cfg_q <= bmm_pkg::SHARED_RST;
		end else if (cfg_we) begin
			case (bmm_pkg::cfg_idx_t'(cfg_index))
				bmm_pkg::CFG_ROWS:   rows_cfg_q   <= cfg_data;
				bmm_pkg::CFG_INNER:  inner_cfg_q  <= cfg_data;
				bmm_pkg::CFG_COLS:   cols_cfg_q   <= cfg_data;
				bmm_pkg::CFG_BATCH:  batch_cfg_q  <= cfg_data[bmm_pkg::BAT_CFG_W-1:0];
				bmm_pkg::CFG_SHARED: shared_cfg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective sizes: clamp to the built maximum
	logic [CW-1:0] rows_eff, inner_eff, cols_eff;
	logic [BW-1:0] batches, rbatches;

	assign rows_eff  = (32'(rows_cfg_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(rows_cfg_q);
	assign inner_eff = (32'(inner_cfg_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(inner_cfg_q);
	assign cols_eff  = (32'(cols_cfg_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(cols_cfg_q);
	assign batches   = (32'(batch_cfg_q) > MAX_BATCH) ? BW'(MAX_BATCH) : BW'(batch_cfg_q);
	assign rbatches  = shared_cfg_q ? ((batches != '0) ? BW'(1) : '0) : batches;

	function automatic logic [AW-1:0] addr_of(input logic [31:0] s, input logic [31:0] r,
			input logic [31:0] c);
		return AW'((s * MAX_DIM + r) * MAX_DIM + c);
	endfunction

	// Sequencer state
	bmm_pkg::state_t state_q, state_d;
	logic [bmm_pkg::SLICE_W-1:0] sl_q, rs_q;
	logic [CW-1:0] rows_q, inner_q, cols_q;
	logic          zero_q;
	logic [IW-1:0] i_q, h_q, j_q, d_q;
	logic [WW-1:0] wait_q;

	logic in_xfer, start_ok, start, issue_v, issue_last, drain_step, drain_last, row_last;
	logic load_left_ok, load_right_ok;
	logic res_valid_q;

	assign in_xfer  = items.valid && items.ready;
	assign start_ok = (bmm_pkg::opcode_t'(items.opcode) == bmm_pkg::OP_COMPUTE)
		&& (32'(items.slice) < 32'(batches)) && (rows_eff != '0) && (cols_eff != '0);
	assign start    = in_xfer && start_ok;

	assign load_left_ok = (bmm_pkg::opcode_t'(items.opcode) == bmm_pkg::OP_LOAD_LEFT)
		&& (32'(items.slice) < 32'(batches)) && (32'(items.row) < 32'(rows_eff))
		&& (32'(items.col) < 32'(inner_eff));
	assign load_right_ok = (bmm_pkg::opcode_t'(items.opcode) == bmm_pkg::OP_LOAD_RIGHT)
		&& (32'(items.slice) < 32'(rbatches)) && (32'(items.row) < 32'(inner_eff))
		&& (32'(items.col) < 32'(cols_eff));

	assign issue_last = (32'(h_q) == 32'(inner_q) - 1) && (32'(j_q) == 32'(cols_q) - 1);
	assign drain_last = (32'(d_q) == 32'(cols_q) - 1);
	assign row_last   = (32'(i_q) == 32'(rows_q) - 1);

	function automatic logic drain_last_col(input logic [IW-1:0] c, input logic [CW-1:0] n);
		return 32'(c) == 32'(n) - 1;
	endfunction

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmm_pkg::ST_IDLE: begin
				if (start) state_d = bmm_pkg::ST_ISSUE;
			end
			bmm_pkg::ST_ISSUE: begin
				if (issue_last) state_d = bmm_pkg::ST_WAIT;
			end
			bmm_pkg::ST_WAIT: begin
				if (32'(wait_q) == WAIT_LEN - 1) state_d = bmm_pkg::ST_DRAIN;
			end
			bmm_pkg::ST_DRAIN: begin
				if (drain_step && drain_last) begin
					state_d = row_last ? bmm_pkg::ST_IDLE : bmm_pkg::ST_ISSUE;
				end
			end
			default: state_d = bmm_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		items.ready = (state_q == bmm_pkg::ST_IDLE);
		issue_v     = (state_q == bmm_pkg::ST_ISSUE);
		drain_step  = (state_q == bmm_pkg::ST_DRAIN) && (!res_valid_q || results.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmm_pkg::ST_IDLE;
			sl_q    <= '0;
			rs_q    <= '0;
			rows_q  <= '0;
			inner_q <= '0;
			cols_q  <= '0;
			zero_q  <= 1'b0;
			i_q     <= '0;
			h_q     <= '0;
			j_q     <= '0;
			d_q     <= '0;
			wait_q  <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				// Latch the geometry; an empty inner sum runs one killed pass
				sl_q    <= items.slice;
				rs_q    <= shared_cfg_q ? '0 : items.slice;
				rows_q  <= rows_eff;
				cols_q  <= cols_eff;
				inner_q <= (inner_eff == '0) ? CW'(1) : inner_eff;
				zero_q  <= (inner_eff == '0);
				i_q     <= '0;
				h_q     <= '0;
				j_q     <= '0;
			end
			if (issue_v) begin
				if (drain_last_col(j_q, cols_q)) begin
					j_q <= '0;
					h_q <= issue_last ? '0 : h_q + IW'(1);
				end else begin
					j_q <= j_q + IW'(1);
				end
			end
			wait_q <= (state_q == bmm_pkg::ST_WAIT) ? wait_q + WW'(1) : '0;
			if (state_q == bmm_pkg::ST_WAIT) begin
				d_q <= '0;
			end else if (drain_step) begin
				d_q <= d_q + IW'(1);
				if (drain_last && !row_last) begin
					i_q <= i_q + IW'(1);
					h_q <= '0;
					j_q <= '0;
				end
			end
		end
	end

	// Operand stores
	logic [VW-1:0] left_rd, right_rd;

	bmm_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_left_ram (
		.clk   (clk),
		.we    (in_xfer && load_left_ok),
		.waddr (addr_of(32'(items.slice), 32'(items.row), 32'(items.col))),
		.wdata (items.value),
		.raddr (addr_of(32'(sl_q), 32'(i_q), 32'(h_q))),
		.rdata (left_rd)
	);

	bmm_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_right_ram (
		.clk   (clk),
		.we    (in_xfer && load_right_ok),
		.waddr (addr_of(32'(items.slice), 32'(items.row), 32'(items.col))),
		.wdata (items.value),
		.raddr (addr_of(32'(rs_q), 32'(h_q), 32'(j_q))),
		.rdata (right_rd)
	);

	// Read stage tag, then the shared multiplier
	bmm_pkg::meta_t meta_s1, meta_s2;
	logic signed [bmm_pkg::PROD_W-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
		end else begin
			meta_s1.valid <= issue_v;
			meta_s1.first <= (h_q == '0);
			meta_s1.tag   <= bmm_pkg::TAG_W'(j_q);
			meta_s2       <= meta_s1;
		end
	end

	// Keep the product signed: an empty inner sum feeds zeros
	always_ff @(posedge clk) begin
		if (zero_q) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= $signed(left_rd) * $signed(right_rd);
		end
	end

	// Cell chain: products travel toward the tail, sums drain toward the head
	bmm_pkg::pass_t pass_w [MAX_DIM + 1];
	logic signed [ACC_W-1:0] acc_w [MAX_DIM + 1];

	assign pass_w[0].meta = meta_s2;
	assign pass_w[0].prod = prod_s2;
	assign acc_w[MAX_DIM] = '0;

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		bmm_cell #(.IDX(k), .ACC_W(ACC_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.pass_in  (pass_w[k]),
			.pass_out (pass_w[k + 1]),
			.shift    (drain_step),
			.acc_in   (acc_w[k + 1]),
			.acc_out  (acc_w[k])
		);
	end

	// Floor scaling and saturation of the head sum
	logic signed [ACC_W-1:0] scaled;
	logic [VW-1:0]           sat_val;

	assign scaled = acc_w[0] >>> FRAC_BITS;

	always_comb begin
		if (scaled[ACC_W-1:VW-1] == '0 || scaled[ACC_W-1:VW-1] == '1) begin
			sat_val = scaled[VW-1:0];
		end else begin
			sat_val = scaled[ACC_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
		end
	end

	// Result register: hold until the transfer completes
	logic [bmm_pkg::SLICE_W-1:0] res_slice_q;
	logic [bmm_pkg::ROW_W-1:0]   res_row_q;
	logic [bmm_pkg::COL_W-1:0]   res_col_q;
	logic [VW-1:0]               res_prod_q;
	logic                        res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (drain_step) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_step) begin
			res_slice_q <= sl_q;
			res_row_q   <= bmm_pkg::ROW_W'(i_q);
			res_col_q   <= bmm_pkg::COL_W'(d_q);
			res_prod_q  <= sat_val;
			res_last_q  <= drain_last && row_last;
		end
	end

	assign results.valid     = res_valid_q;
	assign results.out_slice = res_slice_q;
	assign results.out_row   = res_row_q;
	assign results.out_col   = res_col_q;
	assign results.product   = res_prod_q;
	assign results.last      = res_last_q;

	// A read-stage tag only follows an issue cycle
	a_s1_from_issue: assert property (@(posedge clk) disable iff (!arst_n)
		meta_s1.valid |-> $past(state_q) == bmm_pkg::ST_ISSUE)
		else $error("read stage valid without an issue cycle");

	// The chain is flushed before sums shift out
	a_flushed_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bmm_pkg::ST_DRAIN |-> !meta_s1.valid && !meta_s2.valid)
		else $error("products in flight while draining");

	// Every drain step loads the result register
	a_drain_loads: assert property (@(posedge clk) disable iff (!arst_n)
		drain_step |=> res_valid_q)
		else $error("drain step lost a result");
endmodule

[sv/bmm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[sv/bmm_cell.sv]
// One accumulator cell of the result-row chain: passes products on, keeps
// the sum for its own column, and shifts sums toward the head on drain.
// Depends on bmm_pkg.
module bmm_cell #(
	parameter int IDX   = 0,
	parameter int ACC_W = 68
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bmm_pkg::pass_t           pass_in,
	output bmm_pkg::pass_t           pass_out,
	input  logic                     shift,
	input  logic signed [ACC_W-1:0]  acc_in,
	output logic signed [ACC_W-1:0]  acc_out
);
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term;
	logic                    hit;
	bmm_pkg::meta_t          meta_q;
	logic signed [bmm_pkg::PROD_W-1:0] prod_q;

	assign term = {{(ACC_W - bmm_pkg::PROD_W){pass_in.prod[bmm_pkg::PROD_W-1]}}, pass_in.prod};
	assign hit  = pass_in.meta.valid && (pass_in.meta.tag == bmm_pkg::TAG_W'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_q <= '0;
		end else begin
			meta_q <= pass_in.meta;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= pass_in.prod;
		if (shift) begin
			acc_q <= acc_in;
		end else if (hit) begin
			acc_q <= pass_in.meta.first ? term : acc_q + term;
		end
	end

	assign pass_out = '{meta: meta_q, prod: prod_q};
	assign acc_out  = acc_q;
endmodule

[tb/sv/batched_matrix_multiply_top_tb.sv]
// Self-checking testbench for batched_matrix_multiply_top: loads, computes,
// configuration extremes, random streams and backpressure, against a local predictor.
// Depends on bmm_pkg, bmm_if and the block's RTL.
module batched_matrix_multiply_top_tb;
	import bmm_pkg::*;

	localparam int FRAC     = FRAC_BITS_DEF;
	localparam int DIM      = MAX_DIM_DEF;
	localparam int BATCH    = MAX_BATCH_DEF;
	localparam int IDLE_MAX = 8000;

	typedef struct {
		logic [SLICE_W-1:0]        sl;
		logic [ROW_W-1:0]          r;
		logic [COL_W-1:0]          c;
		logic signed [VALUE_W-1:0] p;
		logic                      lst;
	} elem_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bmm_in_if  items ();
	bmm_out_if results ();

	batched_matrix_multiply_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .items(items), .results(results)
	);

	// predictor state: shadow stores, write marks and register copies
	logic signed [VALUE_W-1:0] left_mem [256];
	logic signed [VALUE_W-1:0] right_mem [256];
	bit left_set [256];
	bit right_set [256];
	int rows_reg, inner_reg, cols_reg, batch_reg, shared_reg;

	elem_t product_q[$];
	int errors;
	int hold_req;
	bit calm;
	int item_count;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int cap(int v, int m);
		return v > m ? m : v;
	endfunction

	function automatic int eff_rows();
		return cap(rows_reg, DIM);
	endfunction
	function automatic int eff_inner();
		return cap(inner_reg, DIM);
	endfunction
	function automatic int eff_cols();
		return cap(cols_reg, DIM);
	endfunction
	function automatic int eff_batch();
		return cap(batch_reg, BATCH);
	endfunction
	function automatic int right_batch();
		if (shared_reg != 0)
			return eff_batch() > 0 ? 1 : 0;
		return eff_batch();
	endfunction

	function automatic int slot(int s, int r, int c);
		return (s * DIM + r) * DIM + c;
	endfunction

	// exact sum of products, floor shift, saturate to 32 bits
	function automatic void predict_slice(int s);
		logic signed [71:0] acc, a, b, lim_hi, lim_lo;
		elem_t e;
		int rs;
		lim_hi = 72'sd2147483647;
		lim_lo = -72'sd2147483648;
		rs = shared_reg != 0 ? 0 : s;
		for (int i = 0; i < eff_rows(); i++)
			for (int j = 0; j < eff_cols(); j++) begin
				acc = '0;
				for (int h = 0; h < eff_inner(); h++) begin
					a = left_mem[slot(s, i, h)];
					b = right_mem[slot(rs, h, j)];
					acc += a * b;
				end
				acc = acc >>> FRAC;
				e.sl = SLICE_W'(s);
				e.r = ROW_W'(i);
				e.c = COL_W'(j);
				if (acc > lim_hi)
					e.p = 32'sh7fffffff;
				else if (acc < lim_lo)
					e.p = 32'sh80000000;
				else
					e.p = acc[31:0];
				e.lst = (i + 1 == eff_rows()) && (j + 1 == eff_cols());
				product_q.insert(product_q.size(), e);
			end
	endfunction

	function automatic void predict_item(opcode_t op, int s, int r, int c,
		logic signed [VALUE_W-1:0] v);
		case (op)
			OP_LOAD_LEFT: begin
				if (s < eff_batch() && r < eff_rows() && c < eff_inner()) begin
					left_mem[slot(s, r, c)] = v;
					left_set[slot(s, r, c)] = 1;
				end
			end
			OP_LOAD_RIGHT: begin
				if (s < right_batch() && r < eff_inner() && c < eff_cols()) begin
					right_mem[slot(s, r, c)] = v;
					right_set[slot(s, r, c)] = 1;
				end
			end
			OP_COMPUTE: begin
				if (s < eff_batch())
					predict_slice(s);
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return -1;
			4, 5, 6: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	task automatic report(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// drive one item and hold it until the transfer; random gap before it
	task automatic send_item(opcode_t op, int s, int r, int c,
		logic signed [VALUE_W-1:0] v);
		if (!calm && $urandom_range(0, 5) == 0) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		items.valid  <= 1'b1;
		items.opcode <= op;
		items.slice  <= SLICE_W'(s);
		items.row    <= ROW_W'(r);
		items.col    <= COL_W'(c);
		items.value  <= v;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		predict_item(op, s, r, c, v);
		item_count++;
	endtask

	// load any entry a compute of slice s would read but never saw written
	task automatic fill_missing(int s);
		int rs;
		if (s >= eff_batch())
			return;
		rs = shared_reg != 0 ? 0 : s;
		for (int i = 0; i < eff_rows(); i++)
			for (int h = 0; h < eff_inner(); h++)
				if (!left_set[slot(s, i, h)])
					send_item(OP_LOAD_LEFT, s, i, h, pick_value());
		for (int h = 0; h < eff_inner(); h++)
			for (int j = 0; j < eff_cols(); j++)
				if (!right_set[slot(rs, h, j)])
					send_item(OP_LOAD_RIGHT, rs, h, j, pick_value());
	endtask

	task automatic compute(int s);
		fill_missing(s);
		send_item(OP_COMPUTE, s, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
	endtask

	// drop valid, wait for every result, then let a silent compute finish
	task automatic settle();
		items.valid <= 1'b0;
		@(posedge clk);
		while (product_q.size() != 0) @(posedge clk);
		repeat (DIM * (DIM * DIM + 2 * DIM + 2) + 20) @(posedge clk);
	endtask

	// write enable stays high across back-to-back writes; configure drops it
	task automatic write_reg(cfg_idx_t idx, int data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(data);
		@(posedge clk);
		case (idx)
			CFG_ROWS:   rows_reg = data;
			CFG_INNER:  inner_reg = data;
			CFG_COLS:   cols_reg = data;
			CFG_BATCH:  batch_reg = data;
			CFG_SHARED: shared_reg = data;
			default: ;
		endcase
	endtask

	task automatic configure(int r, int i, int c, int b, int sh);
		settle();
		write_reg(CFG_ROWS, r);
		write_reg(CFG_INNER, i);
		write_reg(CFG_COLS, c);
		write_reg(CFG_BATCH, b);
		write_reg(CFG_SHARED, sh);
		cfg_we <= 1'b0;
	endtask

	// random item: mostly reload-then-compute sequences, some noise
	task automatic random_item();
		int s;
		if ($urandom_range(0, 9) < 7) begin
			s = $urandom_range(0, cap(eff_batch(), BATCH) > 0 ? eff_batch() - 1 : 0);
			repeat ($urandom_range(0, 4)) begin
				if ($urandom_range(0, 1))
					send_item(OP_LOAD_LEFT, s, $urandom_range(0, 7) % (eff_rows() + 1),
						$urandom_range(0, 7) % (eff_inner() + 1), pick_value());
				else
					send_item(OP_LOAD_RIGHT, shared_reg != 0 ? 0 : s,
						$urandom_range(0, 7) % (eff_inner() + 1),
						$urandom_range(0, 7) % (eff_cols() + 1), pick_value());
			end
			compute(s);
		end else begin
			opcode_t op;
			op = opcode_t'($urandom_range(0, 3));
			if (op == OP_COMPUTE)
				compute($urandom_range(0, 3));
			else
				send_item(op, $urandom_range(0, 3), $urandom_range(0, 7),
					$urandom_range(0, 7), pick_value());
		end
	endtask

	task automatic test_directed();
		configure(2, 2, 2, 4, 0);
		send_item(OP_LOAD_LEFT, 0, 0, 0, 32'sh7fffffff);
		send_item(OP_LOAD_LEFT, 0, 0, 1, 32'sh7fffffff);
		send_item(OP_LOAD_LEFT, 0, 1, 0, 32'sh80000000);
		send_item(OP_LOAD_LEFT, 0, 1, 1, 32'sh80000000);
		send_item(OP_LOAD_RIGHT, 0, 0, 0, 32'sh7fffffff);
		send_item(OP_LOAD_RIGHT, 0, 1, 0, 32'sh7fffffff);
		send_item(OP_LOAD_RIGHT, 0, 0, 1, 32'sh80000000);
		send_item(OP_LOAD_RIGHT, 0, 1, 1, 32'sh00010000);
		send_item(OP_COMPUTE, 0, 0, 0, 0);
		// ignored: unused opcode and loads beyond the sizes
		send_item(OP_NOP, 3, 7, 7, 32'sh7fffffff);
		send_item(OP_LOAD_LEFT, 3, 7, 7, -1);
		send_item(OP_LOAD_LEFT, 1, 0, 2, -1);
		send_item(OP_LOAD_RIGHT, 3, 2, 0, -1);
		send_item(OP_LOAD_RIGHT, 1, 0, 7, -1);
		compute(3);
	endtask

	task automatic test_config_extremes();
		configure(0, 3, 3, 2, 0);    // no rows: compute emits nothing
		compute(1);
		configure(3, 0, 3, 2, 1);    // no inner: zero products
		compute(1);
		configure(3, 2, 0, 1, 0);    // no columns
		compute(0);
		configure(1, 1, 1, 0, 1);    // no slice in use
		send_item(OP_LOAD_LEFT, 0, 0, 0, 5);
		send_item(OP_COMPUTE, 0, 0, 0, 0);
		configure(15, 15, 15, 7, 0); // over the top: acts as the maximum
		compute(3);
		send_item(OP_LOAD_LEFT, 3, 7, 7, 32'sh80000000);
		send_item(OP_COMPUTE, 3, 0, 0, 0);
		send_item(OP_COMPUTE, 2, 0, 0, 0);
		configure(8, 8, 8, 4, 1);
		compute(2);
	endtask

	task automatic test_random(int n);
		int target;
		target = item_count + n;
		while (item_count < target) begin
			if ($urandom_range(0, 59) == 0) begin
				if ($urandom_range(0, 5) == 0)
					configure(8, $urandom_range(1, 8), 8, $urandom_range(1, 4),
						$urandom_range(0, 1));
				else
					configure($urandom_range(1, 3), $urandom_range(1, 3),
						$urandom_range(1, 3), $urandom_range(1, 4), $urandom_range(0, 1));
			end
			random_item();
		end
	endtask

	// receiver holds off while the sender keeps offering computes
	task automatic test_backpressure();
		configure(3, 3, 3, 4, 0);
		for (int s = 0; s < 4; s++)
			fill_missing(s);
		hold_req = 600;
		for (int k = 0; k < 6; k++)
			send_item(OP_COMPUTE, k % 4, 0, 0, 0);
		send_item(OP_LOAD_LEFT, 1, 2, 2, pick_value());
		send_item(OP_COMPUTE, 1, 0, 0, 0);
	endtask

	// sender pauses until every result has come back
	task automatic test_drain_pause();
		compute(2);
		items.valid <= 1'b0;
		@(posedge clk);
		while (product_q.size() != 0) @(posedge clk);
		compute(0);
	endtask

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		elem_t e;
		if (arst_n && results.valid && results.ready) begin
			if (product_q.size() == 0) begin
				report("unexpected result slice", results.out_slice, -1);
			end else begin
				e = product_q.pop_front();
				if (results.out_slice !== e.sl) report("out_slice", results.out_slice, e.sl);
				if (results.out_row !== e.r) report("out_row", results.out_row, e.r);
				if (results.out_col !== e.c) report("out_col", results.out_col, e.c);
				if (results.product !== e.p) report("product", results.product, e.p);
				if (results.last !== e.lst) report("last", results.last, e.lst);
			end
		end
	end

	// result ready: random stall bursts, long hold on request, steady when calm
	initial begin
		int burst;
		int hold_left;
		burst = 0;
		hold_left = 0;
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				results.ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				results.ready <= 1'b1;
			end else if (burst > 0) begin
				burst--;
			end else if ($urandom_range(0, 3) == 0) begin
				results.ready <= 1'b0;
				burst = $urandom_range(0, 6);
			end else begin
				results.ready <= 1'b1;
				burst = $urandom_range(0, 15);
			end
		end
	end

	// end the run when no transfer happens for too long
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((items.valid && items.ready) || (results.valid && results.ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_MAX) begin
				$display("batched_matrix_multiply_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		hold_req = 0;
		calm = 0;
		item_count = 0;
		rows_reg = ROWS_RST;
		inner_reg = INNER_RST;
		cols_reg = COLS_RST;
		batch_reg = BATCH_RST;
		shared_reg = SHARED_RST;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data = '0;
		items.valid = 1'b0;
		items.opcode = OP_NOP;
		items.slice = '0;
		items.row = '0;
		items.col = '0;
		items.value = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_extremes();
		test_random(50);
		test_backpressure();
		test_drain_pause();
		test_random(30);
		// last stretch with no idling on either side
		calm = 1;
		test_random(40);

		settle();
		if (errors == 0)
			$display("batched_matrix_multiply_top verification clean");
		else
			$display("batched_matrix_multiply_top verification failed");
		$finish;
	end

endmodule

[batched_matrix_multiply_top.f]
sv/bmm_pkg.sv
sv/bmm_if.sv
sv/bmm_ram.sv
sv/bmm_cell.sv
sv/batched_matrix_multiply_top.sv
tb/sv/batched_matrix_multiply_top_tb.sv
